>>> src/mdf_pkg.sv
// mdf_pkg: shared widths, the scaled 1/pi constant and the structs passed between
// the dipole field modules. No dependencies.
`default_nettype none

package mdf_pkg;

    localparam int DEF_COORD_BITS = 20;
    localparam int DEF_FIELD_BITS = 48;

    // offsets are normalized below 2^NORM_BITS before any product is formed
    localparam int NORM_BITS = 20;
    localparam int DN_W      = NORM_BITS + 1;
    localparam int MO_W      = 16;
    localparam int PROD_W    = MO_W + DN_W;
    localparam int SQ_W      = 2 * NORM_BITS;
    localparam int MD_W      = PROD_W + 1;
    localparam int R2_W      = SQ_W + 2;
    localparam int RAD_SHIFT = 20;
    localparam int RQ_W      = (R2_W + RAD_SHIFT) / 2;
    localparam int R2SQ_W    = 2 * R2_W;
    localparam int DEN_W     = R2SQ_W + RQ_W;
    localparam int AN_W      = 60;
    localparam int KC_W      = 61;
    localparam int NUM_W     = AN_W + KC_W + 1;

    // 10^9 * 2^32 / pi, rounded from the 2^64 / pi word
    localparam logic [127:0] KC_FULL =
        ((128'd1000000000 * 128'h517CC1B727220A95) + (128'd1 << 31)) >> 32;
    localparam logic [KC_W-1:0] KC = KC_FULL[KC_W-1:0];

    typedef struct packed {
        logic [MD_W-1:0]           md;
        logic [R2_W-1:0]           r2;
        logic [2:0][DN_W-1:0]      dn;
        logic [2:0][MO_W-1:0]      mo;
        logic                      coin;
    } geo_t;

    typedef struct packed {
        logic [MD_W-1:0]  md;
        logic [R2_W-1:0]  r2;
        logic [DN_W-1:0]  dn;
        logic [MO_W-1:0]  mo;
        logic [DEN_W-1:0] den;
        logic             coin;
    } lane_in_t;

endpackage

`default_nettype wire

>>> src/mdf_isqrt.sv
// mdf_isqrt: pipelined floor square root, one result bit per stage, with a side
// payload that travels alongside. No package dependencies.
`default_nettype none

module mdf_isqrt #(
    parameter int IN_W   = 62,
    parameter int SIDE_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [IN_W-1:0]   radicand,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [(IN_W+(IN_W%2))/2-1:0] root,
    output logic [SIDE_W-1:0] side_out
);

    localparam int RAD_W = IN_W + (IN_W % 2);
    localparam int RW    = RAD_W / 2;

    logic [RW+1:0]     rem_q  [RW+1];
    logic [RW-1:0]     root_q [RW+1];
    logic [RAD_W-1:0]  rad_q  [RW+1];
    logic [SIDE_W-1:0] side_q [RW+1];
    logic              vld_q  [RW+1];

    assign rem_q[0]  = '0;
    assign root_q[0] = '0;
    assign rad_q[0]  = RAD_W'(radicand);
    assign side_q[0] = side_in;
    assign vld_q[0]  = in_valid;

    genvar g;
    for (g = 0; g < RW; g++) begin : g_stage
        logic [RW+1:0]     rem_sh;
        logic [RW+1:0]     trial;
        logic [RW+1:0]     rem_reg;
        logic [RW-1:0]     root_reg;
        logic [RAD_W-1:0]  rad_reg;
        logic [SIDE_W-1:0] side_reg;
        logic              vld_reg;

        assign rem_sh = {rem_q[g][RW-1:0], rad_q[g][RAD_W-1 -: 2]};
        assign trial  = {root_q[g], 2'b01};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg <= 1'b0;
            end
            else
            begin
                vld_reg <= vld_q[g];
            end
        end

        always_ff @(posedge clk)
        begin
            if (rem_sh >= trial)
            begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_q[g][RW-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_q[g][RW-2:0], 1'b0};
            end
            rad_reg  <= rad_q[g] << 2;
            side_reg <= side_q[g];
        end

        assign rem_q[g+1]  = rem_reg;
        assign root_q[g+1] = root_reg;
        assign rad_q[g+1]  = rad_reg;
        assign side_q[g+1] = side_reg;
        assign vld_q[g+1]  = vld_reg;
    end

    assign out_valid = vld_q[RW];
    assign root      = root_q[RW];
    assign side_out  = side_q[RW];

endmodule

`default_nettype wire

>>> src/mdf_lane.sv
// mdf_lane: one field axis: numerator, scaling by 10^9*2^32/pi, pipelined restoring
// division by r^5, rounding and clipping. Depends on mdf_pkg.
`default_nettype none

module mdf_lane
    import mdf_pkg::*;
#(
    parameter int FIELD_BITS = DEF_FIELD_BITS,
    parameter int KW         = 1,
    parameter int QB         = DEF_FIELD_BITS + 2
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  lane_in_t                     lane_in,
    input  logic [KW-1:0]                k,
    output logic                         out_valid,
    output logic signed [FIELD_BITS-1:0] field,
    output logic [FIELD_BITS-1:0]        mag,
    output logic                         clip
);

    localparam int A_W  = MD_W + DN_W;
    localparam int B_W  = R2_W + 1 + MO_W;
    localparam int N_W  = A_W + 3;
    localparam int AN_L = AN_W / 2;
    localparam int AN_H = AN_W - AN_L;
    localparam int KC_L = 31;
    localparam int KC_H = KC_W - KC_L;
    localparam int RM_W = DEN_W + 1;
    localparam logic [KC_L-1:0] KC_LO = KC[KC_L-1:0];
    localparam logic [KC_H-1:0] KC_HI = KC[KC_W-1:KC_L];
    localparam logic [FIELD_BITS-1:0] MAXPOS = {1'b0, {(FIELD_BITS-1){1'b1}}};
    localparam logic [FIELD_BITS-1:0] MAXNEG = {1'b1, {(FIELD_BITS-1){1'b0}}};

    // front stages: numerator and scaled numerator
    logic               vld_reg [5];
    logic [DEN_W-1:0]   den_reg [5];
    logic               coin_reg [5];
    logic [KW-1:0]      k_reg [5];
    logic signed [A_W-1:0] a_reg;
    logic signed [B_W-1:0] b_reg;
    logic signed [N_W-1:0] n_reg;
    logic               neg_reg [3:5];
    logic [AN_W-1:0]    an_reg;
    logic [AN_L+KC_L-1:0] pp_ll_reg;
    logic [AN_L+KC_H-1:0] pp_lh_reg;
    logic [AN_H+KC_L-1:0] pp_hl_reg;
    logic [AN_H+KC_H-1:0] pp_hh_reg;
    logic [NUM_W-1:0]   num_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 5; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < 5; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg[0]  <= lane_in.den;
        coin_reg[0] <= lane_in.coin;
        k_reg[0]    <= k;
        for (int i = 1; i < 5; i++)
        begin
            den_reg[i]  <= den_reg[i-1];
            coin_reg[i] <= coin_reg[i-1];
            k_reg[i]    <= k_reg[i-1];
        end
        a_reg <= $signed(lane_in.md) * $signed(lane_in.dn);
        b_reg <= $signed({1'b0, lane_in.r2}) * $signed(lane_in.mo);
        n_reg <= N_W'(a_reg) + N_W'(a_reg) + N_W'(a_reg) - N_W'(b_reg);
        neg_reg[3] <= n_reg[N_W-1];
        an_reg     <= n_reg[N_W-1] ? AN_W'(-n_reg) : AN_W'(n_reg);
        neg_reg[4] <= neg_reg[3];
        pp_ll_reg  <= an_reg[AN_L-1:0] * KC_LO;
        pp_lh_reg  <= an_reg[AN_L-1:0] * KC_HI;
        pp_hl_reg  <= an_reg[AN_W-1:AN_L] * KC_LO;
        pp_hh_reg  <= an_reg[AN_W-1:AN_L] * KC_HI;
        neg_reg[5] <= neg_reg[4];
        num_reg    <= ((NUM_W'(pp_hh_reg) << (AN_L + KC_L)) + (NUM_W'(pp_hl_reg) << AN_L)
                     + (NUM_W'(pp_lh_reg) << KC_L) + NUM_W'(pp_ll_reg)) << 1;
    end

    // division chain, entry point is the overflow check on the high numerator bits
    logic [RM_W-1:0]  rem_q  [QB+1];
    logic [QB-1:0]    quo_q  [QB+1];
    logic [QB-1:0]    lo_q   [QB+1];
    logic [DEN_W-1:0] dd_q   [QB+1];
    logic             neg_q  [QB+1];
    logic             ovf_q  [QB+1];
    logic             coin_q [QB+1];
    logic [KW-1:0]    k_q    [QB+1];
    logic             vld_q  [QB+1];

    logic [RM_W-1:0]  rem0_reg;
    logic [QB-1:0]    lo0_reg;
    logic [DEN_W-1:0] den0_reg;
    logic             neg0_reg;
    logic             ovf0_reg;
    logic             coin0_reg;
    logic [KW-1:0]    k0_reg;
    logic             vld0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg <= 1'b0;
        end
        else
        begin
            vld0_reg <= vld_reg[4];
        end
    end

    always_ff @(posedge clk)
    begin
        ovf0_reg  <= num_reg[NUM_W-1:QB] >= den_reg[4];
        rem0_reg  <= RM_W'(num_reg[NUM_W-1:QB]);
        lo0_reg   <= num_reg[QB-1:0];
        den0_reg  <= den_reg[4];
        neg0_reg  <= neg_reg[5];
        coin0_reg <= coin_reg[4];
        k0_reg    <= k_reg[4];
    end

    assign rem_q[0]  = rem0_reg;
    assign quo_q[0]  = '0;
    assign lo_q[0]   = lo0_reg;
    assign dd_q[0]   = den0_reg;
    assign neg_q[0]  = neg0_reg;
    assign ovf_q[0]  = ovf0_reg;
    assign coin_q[0] = coin0_reg;
    assign k_q[0]    = k0_reg;
    assign vld_q[0]  = vld0_reg;

    genvar g;
    for (g = 0; g < QB; g++) begin : g_div
        logic [RM_W-1:0]  rem_sh;
        logic [RM_W-1:0]  rem_reg;
        logic [QB-1:0]    quo_reg;
        logic [QB-1:0]    lo_reg;
        logic [DEN_W-1:0] dd_reg;
        logic             neg_r;
        logic             ovf_r;
        logic             coin_r;
        logic [KW-1:0]    k_r;
        logic             vld_r;

        assign rem_sh = {rem_q[g][DEN_W-1:0], lo_q[g][QB-1]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_r <= 1'b0;
            end
            else
            begin
                vld_r <= vld_q[g];
            end
        end

        always_ff @(posedge clk)
        begin
            if (rem_sh >= {1'b0, dd_q[g]})
            begin
                rem_reg <= rem_sh - {1'b0, dd_q[g]};
                quo_reg <= {quo_q[g][QB-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_q[g][QB-2:0], 1'b0};
            end
            lo_reg <= lo_q[g] << 1;
            dd_reg <= dd_q[g];
            neg_r  <= neg_q[g];
            ovf_r  <= ovf_q[g];
            coin_r <= coin_q[g];
            k_r    <= k_q[g];
        end

        assign rem_q[g+1]  = rem_reg;
        assign quo_q[g+1]  = quo_reg;
        assign lo_q[g+1]   = lo_reg;
        assign dd_q[g+1]   = dd_reg;
        assign neg_q[g+1]  = neg_r;
        assign ovf_q[g+1]  = ovf_r;
        assign coin_q[g+1] = coin_r;
        assign k_q[g+1]    = k_r;
        assign vld_q[g+1]  = vld_r;
    end

    // round half up after the offset scaling, then clip to the field range
    logic [QB:0]           rsum;
    logic [QB:0]           tval;
    logic [FIELD_BITS-1:0] lim;
    logic                  clip_c;
    logic [FIELD_BITS-1:0] mag_c;

    always_comb
    begin
        rsum   = (QB+1)'(quo_q[QB]) + ((QB+1)'(1) << k_q[QB]);
        tval   = (rsum >> k_q[QB]) >> 1;
        lim    = neg_q[QB] ? MAXNEG : MAXPOS;
        clip_c = coin_q[QB] | ovf_q[QB] | (tval > (QB+1)'(lim));
        mag_c  = clip_c ? lim : tval[FIELD_BITS-1:0];
    end

    logic                  vldo_reg;
    logic [FIELD_BITS-1:0] field_reg;
    logic [FIELD_BITS-1:0] mag_reg;
    logic                  clip_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vldo_reg <= 1'b0;
        end
        else
        begin
            vldo_reg <= vld_q[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_c;
        clip_reg <= clip_c;
        if (coin_q[QB])
        begin
            field_reg <= MAXPOS;
        end
        else
        begin
            field_reg <= neg_q[QB] ? (~mag_c + 1'b1) : mag_c;
        end
    end

    assign out_valid = vldo_reg;
    assign field     = $signed(field_reg);
    assign mag       = mag_reg;
    assign clip      = clip_reg;

endmodule

`default_nettype wire

>>> src/mdf_merge.sv
// mdf_merge: combines the three axis lanes into the magnitude and the final
// registered outputs. Depends on mdf_pkg and mdf_isqrt.
`default_nettype none

module mdf_merge
    import mdf_pkg::*;
#(
    parameter int FIELD_BITS = DEF_FIELD_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [2:0][FIELD_BITS-1:0]   fields,
    input  logic [2:0][FIELD_BITS-1:0]   mags,
    input  logic [2:0]                   clips,
    output logic                         done,
    output logic signed [FIELD_BITS-1:0] field_x,
    output logic signed [FIELD_BITS-1:0] field_y,
    output logic signed [FIELD_BITS-1:0] field_z,
    output logic [FIELD_BITS-1:0]        field_strength,
    output logic                         saturated
);

    localparam int LO_W   = FIELD_BITS / 2;
    localparam int HI_W   = FIELD_BITS - LO_W;
    localparam int S2_W   = 2 * FIELD_BITS;
    localparam int SIDE_W = 3 * FIELD_BITS + 1;

    logic                        v1_reg, v2_reg, v3_reg;
    logic [2*HI_W-1:0]           hh_reg [3];
    logic [HI_W+LO_W-1:0]        hl_reg [3];
    logic [2*LO_W-1:0]           ll_reg [3];
    logic [S2_W-1:0]             sq_reg [3];
    logic [S2_W-1:0]             tot_reg;
    logic [2:0][FIELD_BITS-1:0]  f1_reg, f2_reg, f3_reg;
    logic                        s1_reg, s2_reg, s3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            hh_reg[i] <= mags[i][FIELD_BITS-1:LO_W] * mags[i][FIELD_BITS-1:LO_W];
            hl_reg[i] <= mags[i][FIELD_BITS-1:LO_W] * mags[i][LO_W-1:0];
            ll_reg[i] <= mags[i][LO_W-1:0] * mags[i][LO_W-1:0];
            sq_reg[i] <= (S2_W'(hh_reg[i]) << (2 * LO_W)) + (S2_W'(hl_reg[i]) << (LO_W + 1))
                         + S2_W'(ll_reg[i]);
        end
        tot_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
        f1_reg  <= fields;
        f2_reg  <= f1_reg;
        f3_reg  <= f2_reg;
        s1_reg  <= |clips;
        s2_reg  <= s1_reg;
        s3_reg  <= s2_reg;
    end

    logic                  rt_valid;
    logic [FIELD_BITS-1:0] rt_root;
    logic [SIDE_W-1:0]     rt_side;

    mdf_isqrt #(
        .IN_W   (S2_W),
        .SIDE_W (SIDE_W)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3_reg),
        .radicand  (tot_reg),
        .side_in   ({f3_reg, s3_reg}),
        .out_valid (rt_valid),
        .root      (rt_root),
        .side_out  (rt_side)
    );

    logic                  done_reg;
    logic [FIELD_BITS-1:0] fx_reg, fy_reg, fz_reg, fs_reg;
    logic                  sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= rt_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        fx_reg  <= rt_side[1 +: FIELD_BITS];
        fy_reg  <= rt_side[1 + FIELD_BITS +: FIELD_BITS];
        fz_reg  <= rt_side[1 + 2*FIELD_BITS +: FIELD_BITS];
        sat_reg <= rt_side[0];
        fs_reg  <= rt_side[0] ? {FIELD_BITS{1'b1}} : rt_root;
    end

    assign done           = done_reg;
    assign field_x        = $signed(fx_reg);
    assign field_y        = $signed(fy_reg);
    assign field_z        = $signed(fz_reg);
    assign field_strength = fs_reg;
    assign saturated      = sat_reg;

endmodule

`default_nettype wire

>>> src/magnetic_dipole_field.sv
// magnetic dipole field, fully pipelined: a new transaction can start every cycle.
// the path runs through the r sqrt (31 stages), the per-axis restoring divider and the
// magnitude sqrt.
// throughput: one transaction per cycle; busy stays low, results show on done for one cycle.
// reset: asynchronous active-low rst_n clears all valid flags, nothing is stored.
// Depends on mdf_pkg, mdf_isqrt, mdf_lane and mdf_merge.
`default_nettype none

module magnetic_dipole_field
    import mdf_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int FIELD_BITS = DEF_FIELD_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] tx_x,
    input  logic signed [COORD_BITS-1:0] tx_y,
    input  logic signed [COORD_BITS-1:0] tx_z,
    input  logic signed [COORD_BITS-1:0] rx_x,
    input  logic signed [COORD_BITS-1:0] rx_y,
    input  logic signed [COORD_BITS-1:0] rx_z,
    input  logic signed [MO_W-1:0]       moment_x,
    input  logic signed [MO_W-1:0]       moment_y,
    input  logic signed [MO_W-1:0]       moment_z,
    output logic                         done,
    output logic signed [FIELD_BITS-1:0] field_x,
    output logic signed [FIELD_BITS-1:0] field_y,
    output logic signed [FIELD_BITS-1:0] field_z,
    output logic [FIELD_BITS-1:0]        field_strength,
    output logic                         saturated
);

    localparam int SMAX   = (COORD_BITS > NORM_BITS) ? COORD_BITS - NORM_BITS : 0;
    localparam int SW     = (SMAX > 0) ? $clog2(SMAX + 1) : 1;
    localparam int KMAX   = 3 * SMAX;
    localparam int KW     = (KMAX > 0) ? $clog2(KMAX + 1) : 1;
    localparam int QB     = FIELD_BITS + 2 + KMAX;
    localparam int BL_W   = $clog2(COORD_BITS + 1);
    localparam int SIDE_W = KW + $bits(geo_t);
    localparam int R2_LO  = R2_W / 2;
    localparam int R2_HI  = R2_W - R2_LO;
    localparam int SEG    = R2SQ_W / 3;
    localparam int SEG_T  = R2SQ_W - 2 * SEG;

    logic accept;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // offsets and their magnitudes
    logic signed [COORD_BITS:0] d [3];
    logic signed [COORD_BITS-1:0] txs [3];
    logic signed [COORD_BITS-1:0] rxs [3];

    assign txs[0] = tx_x;
    assign txs[1] = tx_y;
    assign txs[2] = tx_z;
    assign rxs[0] = rx_x;
    assign rxs[1] = rx_y;
    assign rxs[2] = rx_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d[i] = (COORD_BITS+1)'(rxs[i]) - (COORD_BITS+1)'(txs[i]);
        end
    end

    logic                  v1_reg;
    logic                  neg1_reg [3];
    logic [COORD_BITS-1:0] mag1_reg [3];
    logic [2:0][MO_W-1:0]  mo1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            neg1_reg[i] <= d[i][COORD_BITS];
            mag1_reg[i] <= d[i][COORD_BITS] ? COORD_BITS'(-d[i]) : COORD_BITS'(d[i]);
        end
        mo1_reg <= {moment_z, moment_y, moment_x};
    end

    // normalizing shift from the bit length of the largest offset
    logic [COORD_BITS-1:0] mor;
    logic [BL_W-1:0]       blen;
    logic [SW-1:0]         shamt;
    logic [NORM_BITS-1:0]  nmag [3];

    always_comb
    begin
        mor  = mag1_reg[0] | mag1_reg[1] | mag1_reg[2];
        blen = '0;
        for (int i = 0; i < COORD_BITS; i++)
        begin
            if (mor[i])
            begin
                blen = BL_W'(i + 1);
            end
        end
        shamt = (int'(blen) > NORM_BITS) ? SW'(int'(blen) - NORM_BITS) : '0;
        for (int i = 0; i < 3; i++)
        begin
            nmag[i] = NORM_BITS'(mag1_reg[i] >> shamt);
        end
    end

    logic                   v2_reg;
    logic signed [DN_W-1:0] dn2_reg [3];
    logic [2:0][MO_W-1:0]   mo2_reg;
    logic [KW-1:0]          k2_reg;
    logic                   coin2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            dn2_reg[i] <= neg1_reg[i] ? -$signed(DN_W'(nmag[i])) : $signed(DN_W'(nmag[i]));
        end
        mo2_reg   <= mo1_reg;
        k2_reg    <= KW'(shamt) + KW'(shamt) + KW'(shamt);
        coin2_reg <= (mor == '0);
    end

    // dot product and squared length
    logic                     v3_reg, v4_reg;
    logic signed [PROD_W-1:0] p3_reg [3];
    logic [SQ_W-1:0]          sq3_reg [3];
    logic [2:0][DN_W-1:0]     dn3_reg, dn4_reg;
    logic [2:0][MO_W-1:0]     mo3_reg, mo4_reg;
    logic [KW-1:0]            k3_reg, k4_reg;
    logic                     coin3_reg, coin4_reg;
    logic signed [MD_W-1:0]   md4_reg;
    logic [R2_W-1:0]          r24_reg;
    logic signed [2*DN_W-1:0] sqfull [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sqfull[i] = dn2_reg[i] * dn2_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            p3_reg[i]  <= $signed(mo2_reg[i]) * dn2_reg[i];
            sq3_reg[i] <= sqfull[i][SQ_W-1:0];
            dn3_reg[i] <= dn2_reg[i];
        end
        mo3_reg   <= mo2_reg;
        k3_reg    <= k2_reg;
        coin3_reg <= coin2_reg;
        md4_reg   <= MD_W'(p3_reg[0]) + MD_W'(p3_reg[1]) + MD_W'(p3_reg[2]);
        r24_reg   <= R2_W'(sq3_reg[0]) + R2_W'(sq3_reg[1]) + R2_W'(sq3_reg[2]);
        dn4_reg   <= dn3_reg;
        mo4_reg   <= mo3_reg;
        k4_reg    <= k3_reg;
        coin4_reg <= coin3_reg;
    end

    // r in mm with 10 fraction bits
    geo_t             geo4;
    logic             rq_valid;
    logic [RQ_W-1:0]  rq;
    logic [SIDE_W-1:0] rq_side;

    always_comb
    begin
        geo4.md   = md4_reg;
        geo4.r2   = r24_reg;
        geo4.dn   = dn4_reg;
        geo4.mo   = mo4_reg;
        geo4.coin = coin4_reg;
    end

    mdf_isqrt #(
        .IN_W   (R2_W + RAD_SHIFT),
        .SIDE_W (SIDE_W)
    ) u_rsqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v4_reg),
        .radicand  ({r24_reg, {RAD_SHIFT{1'b0}}}),
        .side_in   ({k4_reg, geo4}),
        .out_valid (rq_valid),
        .root      (rq),
        .side_out  (rq_side)
    );

    // denominator r2 * r2 * rq, in partial products
    geo_t                     geo_r;
    logic                     vd_reg [4];
    geo_t                     geod_reg [4];
    logic [KW-1:0]            kd_reg [4];
    logic [RQ_W-1:0]          rqd_reg [2];
    logic [2*R2_HI-1:0]       hh_reg;
    logic [R2_HI+R2_LO-1:0]   hl_reg;
    logic [2*R2_LO-1:0]       ll_reg;
    logic [R2SQ_W-1:0]        r2sq_reg;
    logic [SEG+RQ_W-1:0]      pd0_reg, pd1_reg;
    logic [SEG_T+RQ_W-1:0]    pd2_reg;
    logic [DEN_W-1:0]         den_reg;

    assign geo_r = rq_side[$bits(geo_t)-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                vd_reg[i] <= 1'b0;
            end
        end
        else
        begin
            vd_reg[0] <= rq_valid;
            for (int i = 1; i < 4; i++)
            begin
                vd_reg[i] <= vd_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        geod_reg[0] <= geo_r;
        kd_reg[0]   <= rq_side[SIDE_W-1 -: KW];
        for (int i = 1; i < 4; i++)
        begin
            geod_reg[i] <= geod_reg[i-1];
            kd_reg[i]   <= kd_reg[i-1];
        end
        rqd_reg[0] <= rq;
        rqd_reg[1] <= rqd_reg[0];
        hh_reg   <= geo_r.r2[R2_W-1:R2_LO] * geo_r.r2[R2_W-1:R2_LO];
        hl_reg   <= geo_r.r2[R2_W-1:R2_LO] * geo_r.r2[R2_LO-1:0];
        ll_reg   <= geo_r.r2[R2_LO-1:0] * geo_r.r2[R2_LO-1:0];
        r2sq_reg <= (R2SQ_W'(hh_reg) << (2 * R2_LO)) + (R2SQ_W'(hl_reg) << (R2_LO + 1))
                    + R2SQ_W'(ll_reg);
        pd0_reg  <= r2sq_reg[SEG-1:0] * rqd_reg[1];
        pd1_reg  <= r2sq_reg[2*SEG-1:SEG] * rqd_reg[1];
        pd2_reg  <= r2sq_reg[R2SQ_W-1:2*SEG] * rqd_reg[1];
        den_reg  <= (DEN_W'(pd2_reg) << (2 * SEG)) + (DEN_W'(pd1_reg) << SEG) + DEN_W'(pd0_reg);
    end

    // three axis lanes
    lane_in_t                   lin [3];
    logic [2:0]                 lane_vld;
    logic [2:0][FIELD_BITS-1:0] lane_field;
    logic [2:0][FIELD_BITS-1:0] lane_mag;
    logic [2:0]                 lane_clip;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            lin[i].md   = geod_reg[3].md;
            lin[i].r2   = geod_reg[3].r2;
            lin[i].dn   = geod_reg[3].dn[i];
            lin[i].mo   = geod_reg[3].mo[i];
            lin[i].den  = den_reg;
            lin[i].coin = geod_reg[3].coin;
        end
    end

    genvar ax;
    for (ax = 0; ax < 3; ax++) begin : g_lane
        mdf_lane #(
            .FIELD_BITS (FIELD_BITS),
            .KW         (KW),
            .QB         (QB)
        ) u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (vd_reg[3]),
            .lane_in   (lin[ax]),
            .k         (kd_reg[3]),
            .out_valid (lane_vld[ax]),
            .field     (lane_field[ax]),
            .mag       (lane_mag[ax]),
            .clip      (lane_clip[ax])
        );
    end

    mdf_merge #(
        .FIELD_BITS (FIELD_BITS)
    ) u_merge (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (&lane_vld),
        .fields         (lane_field),
        .mags           (lane_mag),
        .clips          (lane_clip),
        .done           (done),
        .field_x        (field_x),
        .field_y        (field_y),
        .field_z        (field_z),
        .field_strength (field_strength),
        .saturated      (saturated)
    );

endmodule

`default_nettype wire
